// ----- rtl/i2cms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the i2c master bit sequencer: command codes,
// the queue entry between front and back, and the last slot index per command.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes on the mode input
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_SACK  = 3'd4;
  localparam logic [2:0] MODE_RACK  = 3'd5;

  // default depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // slot counter width and last slot index of each command
  localparam int unsigned SLOT_W = 5;
  localparam logic [SLOT_W-1:0] LAST_START = 5'd3;
  localparam logic [SLOT_W-1:0] LAST_STOP  = 5'd2;
  localparam logic [SLOT_W-1:0] LAST_WRITE = 5'd23;
  localparam logic [SLOT_W-1:0] LAST_READ  = 5'd24;
  localparam logic [SLOT_W-1:0] LAST_SACK  = 5'd2;
  localparam logic [SLOT_W-1:0] LAST_RACK  = 5'd3;

  // decoded command
  typedef enum logic [2:0] {
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_SACK,
    CMD_RACK
  } cmd_e;

  // classified request as it waits in the queue
  typedef struct packed {
    logic       start;       // a legal command is offered
    cmd_e       cmd;
    logic [7:0] shift_init;  // shift register load if the command starts
    logic       sda_in;
  } q_item_t;

endpackage
`default_nettype wire

// ----- rtl/i2c_master_bit_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit engine: each request is one bus timing slot that drives
// open-drain SCL/SDA levels or samples SDA, running start, stop, byte and ack
// commands. A decoding front end and a slot sequencer meet at a short queue.
//
//   channel  valid       stall        payload
//   in       in_valid_i  in_stall_o   cmd_valid_i mode_i tx_byte_i
//                                      tx_ack_bit_i sda_in_i
//   out      out_valid_o out_stall_i  scl_out_o sda_out_o busy_res_o
//                                      done_res_o rx_byte_o rx_ack_o
//
// One request per cycle sustained while out_stall_i is low; the sequencer
// registers each slot update, and a request passes through the queue
// storage and then the result register.
// Reset leaves the sequencer idle with both lines released and rx_ack high.
// Output stall holds the result register; the queue absorbs the requests in
// flight and in_stall_o rises only when the queue is full.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
  parameter int unsigned QueueDepth = i2cms_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       cmd_valid_i,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       tx_ack_bit_i,
  input  wire logic       sda_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_out_o,
  output logic            sda_out_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o,
  output logic            rx_ack_o
);

  logic               q_valid;
  logic               q_pop;
  i2cms_pkg::q_item_t q_item;

  // request decode and queue
  i2cms_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_valid_i  (cmd_valid_i),
    .mode_i       (mode_i),
    .tx_byte_i    (tx_byte_i),
    .tx_ack_bit_i (tx_ack_bit_i),
    .sda_in_i     (sda_in_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  // slot sequencer and result register
  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .rx_ack_o    (rx_ack_o)
  );

endmodule
`default_nettype wire

// ----- rtl/i2cms_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts requests, decodes the offered command and its shift register load,
// and holds classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module i2cms_front #(
  parameter int unsigned Depth = i2cms_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_valid_i,
  input  wire logic [2:0]          mode_i,
  input  wire logic [7:0]          tx_byte_i,
  input  wire logic                tx_ack_bit_i,
  input  wire logic                sda_in_i,
  output logic                     q_valid_o,
  output i2cms_pkg::q_item_t       q_item_o,
  input  wire logic                q_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  i2cms_pkg::q_item_t            item;
  i2cms_pkg::q_item_t            mem_q [Depth];
  logic [PtrW-1:0]               wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          push;

  // classify the offered command
  always_comb begin
    item.start      = cmd_valid_i;
    item.cmd        = i2cms_pkg::CMD_START;
    item.shift_init = 8'h00;
    item.sda_in     = sda_in_i;
    case (mode_i)
      i2cms_pkg::MODE_START: item.cmd = i2cms_pkg::CMD_START;
      i2cms_pkg::MODE_STOP:  item.cmd = i2cms_pkg::CMD_STOP;
      i2cms_pkg::MODE_WRITE: begin
        item.cmd        = i2cms_pkg::CMD_WRITE;
        item.shift_init = tx_byte_i;
      end
      i2cms_pkg::MODE_READ:  item.cmd = i2cms_pkg::CMD_READ;
      i2cms_pkg::MODE_SACK: begin
        item.cmd        = i2cms_pkg::CMD_SACK;
        item.shift_init = {7'b0, tx_ack_bit_i};
      end
      i2cms_pkg::MODE_RACK:  item.cmd = i2cms_pkg::CMD_RACK;
      default:               item.start = 1'b0;
    endcase
  end

  // queue control
  assign in_stall_o = (cnt_q == CntFull);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

`ifndef NO_ASSERTIONS
  // fill level never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("queue fill level above depth");

  // back end only takes from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  // a lone push grows the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push lost in queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/i2cms_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_back
// Runs one bus slot per queued request: command phase, slot counter, shift
// register and line levels, with the result held in an output register.
// ----------------------------------------------------------------------------
module i2cms_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire i2cms_pkg::q_item_t  q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     scl_out_o,
  output logic                     sda_out_o,
  output logic                     busy_res_o,
  output logic                     done_res_o,
  output logic [7:0]               rx_byte_o,
  output logic                     rx_ack_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_STOP,
    PH_WRITE,
    PH_READ,
    PH_SACK,
    PH_RACK
  } phase_e;

  localparam int unsigned SW = i2cms_pkg::SLOT_W;

  phase_e            phase_q, phase_d, ph;
  logic [SW-1:0]     slot_q, slot_d, s;
  logic [1:0]        sub_q, sub_d, sub;
  logic [7:0]        shift_q, shift_d, sh;
  logic [7:0]        rxb_q, rxb_d;
  logic              rxack_q, rxack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              out_valid_q, out_valid_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              cmd_start;
  phase_e            new_phase;

  // last slot index of a command
  function automatic logic [SW-1:0] last_slot(input phase_e p);
    logic [SW-1:0] r;
    case (p)
      PH_START: r = i2cms_pkg::LAST_START;
      PH_STOP:  r = i2cms_pkg::LAST_STOP;
      PH_WRITE: r = i2cms_pkg::LAST_WRITE;
      PH_READ:  r = i2cms_pkg::LAST_READ;
      PH_SACK:  r = i2cms_pkg::LAST_SACK;
      PH_RACK:  r = i2cms_pkg::LAST_RACK;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // take a request when the output register is free or being emptied
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // phase a newly accepted command enters
  always_comb begin
    case (q_item_i.cmd)
      i2cms_pkg::CMD_START: new_phase = PH_START;
      i2cms_pkg::CMD_STOP:  new_phase = PH_STOP;
      i2cms_pkg::CMD_WRITE: new_phase = PH_WRITE;
      i2cms_pkg::CMD_READ:  new_phase = PH_READ;
      i2cms_pkg::CMD_SACK:  new_phase = PH_SACK;
      i2cms_pkg::CMD_RACK:  new_phase = PH_RACK;
      default:              new_phase = PH_IDLE;
    endcase
  end

  // one slot of the running command
  always_comb begin
    cmd_start   = (phase_q == PH_IDLE) && q_item_i.start;
    ph          = cmd_start ? new_phase : phase_q;
    s           = cmd_start ? '0 : slot_q;
    sub         = cmd_start ? 2'd0 : sub_q;
    sh          = cmd_start ? q_item_i.shift_init : shift_q;

    phase_d     = phase_q;
    slot_d      = slot_q;
    sub_d       = sub_q;
    shift_d     = shift_q;
    rxb_d       = rxb_q;
    rxack_d     = rxack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    busy_d      = busy_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (q_pop_o) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
      done_d      = 1'b0;
      if (ph != PH_IDLE) begin
        busy_d  = 1'b1;
        phase_d = ph;
        shift_d = sh;
        case (ph)
          PH_START: begin
            if (s == 5'd0) sda_d = 1'b1;
            else if (s == 5'd1) scl_d = 1'b1;
            else if (s == 5'd2) sda_d = 1'b0;
            else scl_d = 1'b0;
          end
          PH_STOP: begin
            if (s == 5'd0) sda_d = 1'b0;
            else if (s == 5'd1) scl_d = 1'b1;
            else sda_d = 1'b1;
          end
          PH_WRITE: begin
            if (sub == 2'd0) sda_d = sh[7];
            else if (sub == 2'd1) scl_d = 1'b1;
            else begin
              scl_d   = 1'b0;
              shift_d = {sh[6:0], 1'b0};
            end
          end
          PH_READ: begin
            if (s == 5'd0) sda_d = 1'b1;
            else if (sub == 2'd0) scl_d = 1'b1;
            else if (sub == 2'd1) shift_d = {sh[6:0], q_item_i.sda_in};
            else begin
              scl_d = 1'b0;
              if (s == i2cms_pkg::LAST_READ) rxb_d = sh;
            end
          end
          PH_SACK: begin
            if (s == 5'd0) sda_d = sh[0];
            else if (s == 5'd1) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          PH_RACK: begin
            if (s == 5'd0) sda_d = 1'b1;
            else if (s == 5'd1) scl_d = 1'b1;
            else if (s == 5'd2) rxack_d = q_item_i.sda_in;
            else scl_d = 1'b0;
          end
          default: ;
        endcase
        // slot and bit-phase counters
        slot_d = s + 1'b1;
        if ((ph == PH_READ) && (s == '0)) sub_d = 2'd0;
        else sub_d = (sub == 2'd2) ? 2'd0 : sub + 1'b1;
        if (s == last_slot(ph)) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
          slot_d  = '0;
          sub_d   = 2'd0;
        end
      end
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      slot_q      <= '0;
      sub_q       <= 2'd0;
      shift_q     <= 8'h00;
      rxb_q       <= 8'h00;
      rxack_q     <= 1'b1;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      sub_q       <= sub_d;
      shift_q     <= shift_d;
      rxb_q       <= rxb_d;
      rxack_q     <= rxack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
    end
  end

  // results
  assign out_valid_o = out_valid_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rxb_q;
  assign rx_ack_o    = rxack_q;

`ifndef NO_ASSERTIONS
  // slot counter stays inside the running command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> slot_q <= last_slot(phase_q))
    else $error("slot counter beyond command length");

  // idle sequencer keeps its counters cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (slot_q == '0) && (sub_q == 2'd0))
    else $error("counters not cleared while idle");

  // a finishing slot returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && done_d) |=> phase_q == PH_IDLE && done_q && busy_q)
    else $error("command did not finish");
`endif

endmodule
`default_nettype wire
